// ----- src/tdis_pkg.sv -----
// ----------------------------------------------------------------------------
// tdis_pkg
// Types, constants and small functions shared by the ternary machine step unit.
// ----------------------------------------------------------------------------
package tdis_pkg;

  localparam int WORD_TRITS = 10;
  localparam int CNT_W      = $clog2(WORD_TRITS);
  localparam int MEM_DEPTH  = 3 ** WORD_TRITS;
  localparam int TOP_WEIGHT = 3 ** (WORD_TRITS - 1);
  localparam int ADDR_W     = $clog2(MEM_DEPTH);
  localparam int WORD_W     = 16;

  localparam logic [WORD_W-1:0] WORD_LAST = WORD_W'(MEM_DEPTH - 1);

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_STEP    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  localparam logic [WORD_W-1:0] INS_LOADD = 16'd42;
  localparam logic [WORD_W-1:0] INS_JUMP  = 16'd94;
  localparam logic [WORD_W-1:0] INS_ROT   = 16'd62;
  localparam logic [WORD_W-1:0] INS_CRAZY = 16'd124;
  localparam logic [WORD_W-1:0] INS_OUT   = 16'd123;
  localparam logic [WORD_W-1:0] INS_IN    = 16'd125;
  localparam logic [WORD_W-1:0] INS_HALT  = 16'd33;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [WORD_W-1:0] load_address;
    logic [WORD_W-1:0] load_value;
    logic [7:0]        in_char;
    logic              in_end;
  } in_item_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       input_taken;
    logic       halted;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDD,
    ST_EXEC,
    ST_CRAZY
  } state_t;

  // x / 3 for 16-bit x by reciprocal multiply
  function automatic logic [WORD_W-1:0] div3(input logic [WORD_W-1:0] x);
    logic [32:0] p;
    p = {17'd0, x} * 33'd43691;
    return p[32:17];
  endfunction

  function automatic logic [1:0] mod3(input logic [WORD_W-1:0] x,
                                      input logic [WORD_W-1:0] q);
    logic [WORD_W-1:0] r;
    r = x - (q + {q[WORD_W-2:0], 1'b0});
    return r[1:0];
  endfunction

  function automatic logic [1:0] crz_trit(input logic [1:0] mt, input logic [1:0] at);
    logic [1:0] r;
    case ({mt, at})
      4'b00_00: r = 2'd1;
      4'b00_01: r = 2'd0;
      4'b00_10: r = 2'd0;
      4'b01_00: r = 2'd1;
      4'b01_01: r = 2'd0;
      4'b01_10: r = 2'd2;
      4'b10_00: r = 2'd2;
      4'b10_01: r = 2'd2;
      4'b10_10: r = 2'd1;
      default:  r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] wrap_next(input logic [WORD_W-1:0] p);
    return (p >= WORD_LAST) ? '0 : p + 16'd1;
  endfunction

endpackage

// ----- src/tdis_mem.sv -----
// ----------------------------------------------------------------------------
// tdis_mem
// Word store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tdis_mem (
  input  logic                           clk,
  input  logic                           we,
  input  logic [tdis_pkg::ADDR_W-1:0]    waddr,
  input  logic [tdis_pkg::WORD_W-1:0]    wdata,
  input  logic [tdis_pkg::ADDR_W-1:0]    raddr,
  output logic [tdis_pkg::WORD_W-1:0]    rdata
);

  logic [tdis_pkg::WORD_W-1:0] mem [tdis_pkg::MEM_DEPTH];
  logic [tdis_pkg::WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- src/tdis_crazy.sv -----
// ----------------------------------------------------------------------------
// tdis_crazy
// Tritwise crazy operation, one trit per cycle from the least significant.
// ----------------------------------------------------------------------------
module tdis_crazy (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [tdis_pkg::WORD_W-1:0] m_in,
  input  logic [tdis_pkg::WORD_W-1:0] a_in,
  output logic                        done,
  output logic [tdis_pkg::WORD_W-1:0] result
);

  logic                        run_r, run_nxt;
  logic                        done_r, done_nxt;
  logic [tdis_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [tdis_pkg::WORD_W-1:0] m_r, m_nxt;
  logic [tdis_pkg::WORD_W-1:0] a_r, a_nxt;
  logic [tdis_pkg::WORD_W-1:0] w_r, w_nxt;
  logic [tdis_pkg::WORD_W-1:0] r_r, r_nxt;
  logic [tdis_pkg::WORD_W-1:0] mq, aq, term;
  logic [1:0]                  mt, at, tr;

  always_comb begin
    mq   = tdis_pkg::div3(m_r);
    aq   = tdis_pkg::div3(a_r);
    mt   = tdis_pkg::mod3(m_r, mq);
    at   = tdis_pkg::mod3(a_r, aq);
    tr   = tdis_pkg::crz_trit(mt, at);
    case (tr)
      2'd1:    term = w_r;
      2'd2:    term = {w_r[tdis_pkg::WORD_W-2:0], 1'b0};
      default: term = '0;
    endcase
  end

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    m_nxt    = m_r;
    a_nxt    = a_r;
    w_nxt    = w_r;
    r_nxt    = r_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      m_nxt   = m_in;
      a_nxt   = a_in;
      w_nxt   = 16'd1;
      r_nxt   = '0;
    end else if (run_r) begin
      m_nxt = mq;
      a_nxt = aq;
      w_nxt = w_r + {w_r[tdis_pkg::WORD_W-2:0], 1'b0};
      r_nxt = r_r + term;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == tdis_pkg::CNT_W'(tdis_pkg::WORD_TRITS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r <= m_nxt;
    a_r <= a_nxt;
    w_r <= w_nxt;
    r_r <= r_nxt;
  end

  assign done   = done_r;
  assign result = r_r;

endmodule

// ----- src/ternary_dis_machine_step_unit.sv -----
// Load, restart and halted-step items get their registered result beat in the next cycle.
// Loads, restarts and halted steps can be taken every cycle; a step holds busy until it is done.
// A step fetches mem[c], then reads mem[d], then executes; the crazy op iterates one trit a cycle.
// The result beat is a one-cycle strobe; the receiver cannot stall.
// Reset clears a, c, d, the halt flag and the control; the word store is not cleared.
// ----------------------------------------------------------------------------
// ternary_dis_machine_step_unit
// Ternary word machine step unit: memory load, restart and single-step execute.
// ----------------------------------------------------------------------------
module ternary_dis_machine_step_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  tdis_pkg::in_item_t   in_item,
  output logic                 out_strobe,
  output tdis_pkg::out_item_t  out_item
);

  tdis_pkg::state_t            state_r, state_nxt;
  logic [tdis_pkg::WORD_W-1:0] a_r, a_nxt;
  logic [tdis_pkg::WORD_W-1:0] c_r, c_nxt;
  logic [tdis_pkg::WORD_W-1:0] d_r, d_nxt;
  logic                        halted_r, halted_nxt;
  logic [tdis_pkg::WORD_W-1:0] ins_r, ins_nxt;
  logic [7:0]                  chr_r, chr_nxt;
  logic                        end_r, end_nxt;
  logic                        out_strobe_r, out_strobe_nxt;
  tdis_pkg::out_item_t         out_item_r, out_item_nxt;

  logic                        mem_we;
  logic [tdis_pkg::ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [tdis_pkg::WORD_W-1:0] mem_wdata, mem_rdata;

  logic                        crz_start, crz_done;
  logic [tdis_pkg::WORD_W-1:0] crz_result;

  logic                        accept, fin, halt, ov, it;
  logic [7:0]                  ob;
  logic [tdis_pkg::WORD_W-1:0] c_tmp, d_tmp, rot, rq, load_mod;
  logic [1:0]                  rm;

  assign accept = start && !busy;
  assign busy   = (state_r != tdis_pkg::ST_IDLE);

  tdis_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tdis_crazy u_crazy (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (crz_start),
    .m_in   (mem_rdata),
    .a_in   (a_r),
    .done   (crz_done),
    .result (crz_result)
  );

  always_comb begin
    rq       = tdis_pkg::div3(mem_rdata);
    rm       = tdis_pkg::mod3(mem_rdata, rq);
    case (rm)
      2'd1:    rot = rq + tdis_pkg::WORD_W'(tdis_pkg::TOP_WEIGHT);
      2'd2:    rot = rq + tdis_pkg::WORD_W'(2 * tdis_pkg::TOP_WEIGHT);
      default: rot = rq;
    endcase
    load_mod = (in_item.load_value > tdis_pkg::WORD_LAST) ?
               in_item.load_value - tdis_pkg::WORD_W'(tdis_pkg::MEM_DEPTH) :
               in_item.load_value;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tdis_pkg::ST_IDLE: begin
        if (accept && in_item.opcode == tdis_pkg::OP_STEP && !halted_r) begin
          state_nxt = tdis_pkg::ST_RDD;
        end
      end
      tdis_pkg::ST_RDD: begin
        state_nxt = tdis_pkg::ST_EXEC;
      end
      tdis_pkg::ST_EXEC: begin
        if (ins_r == tdis_pkg::INS_CRAZY) begin
          state_nxt = tdis_pkg::ST_CRAZY;
        end else begin
          state_nxt = tdis_pkg::ST_IDLE;
        end
      end
      tdis_pkg::ST_CRAZY: begin
        if (crz_done) begin
          state_nxt = tdis_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tdis_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    a_nxt          = a_r;
    c_nxt          = c_r;
    d_nxt          = d_r;
    halted_nxt     = halted_r;
    ins_nxt        = ins_r;
    chr_nxt        = chr_r;
    end_nxt        = end_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    mem_we         = 1'b0;
    mem_waddr      = d_r;
    mem_wdata      = a_r;
    mem_raddr      = (state_r == tdis_pkg::ST_IDLE) ? c_r : d_r;
    crz_start      = 1'b0;
    fin            = 1'b0;
    halt           = 1'b0;
    ov             = 1'b0;
    it             = 1'b0;
    ob             = '0;
    c_tmp          = c_r;
    d_tmp          = d_r;
    case (state_r)
      tdis_pkg::ST_IDLE: begin
        if (accept) begin
          out_strobe_nxt = 1'b1;
          out_item_nxt   = '{out_valid: 1'b0, out_byte: 8'd0, input_taken: 1'b0,
                             halted: halted_r};
          case (in_item.opcode)
            tdis_pkg::OP_LOAD: begin
              if (in_item.load_address <= tdis_pkg::WORD_LAST) begin
                mem_we    = 1'b1;
                mem_waddr = in_item.load_address;
                mem_wdata = load_mod;
              end
            end
            tdis_pkg::OP_RESTART: begin
              a_nxt               = '0;
              c_nxt               = '0;
              d_nxt               = '0;
              halted_nxt          = 1'b0;
              out_item_nxt.halted = 1'b0;
            end
            tdis_pkg::OP_STEP: begin
              if (!halted_r) begin
                out_strobe_nxt = 1'b0;
                chr_nxt        = in_item.in_char;
                end_nxt        = in_item.in_end;
              end
            end
            default: ;
          endcase
        end
      end
      tdis_pkg::ST_RDD: begin
        ins_nxt = mem_rdata;
      end
      tdis_pkg::ST_EXEC: begin
        fin = 1'b1;
        case (ins_r)
          tdis_pkg::INS_LOADD: d_tmp = mem_rdata;
          tdis_pkg::INS_JUMP:  c_tmp = mem_rdata;
          tdis_pkg::INS_ROT: begin
            a_nxt     = rot;
            mem_we    = 1'b1;
            mem_wdata = rot;
          end
          tdis_pkg::INS_CRAZY: begin
            fin       = 1'b0;
            crz_start = 1'b1;
          end
          tdis_pkg::INS_OUT: begin
            if (a_r == tdis_pkg::WORD_LAST) begin
              halt = 1'b1;
            end else begin
              ov = 1'b1;
              ob = a_r[7:0];
            end
          end
          tdis_pkg::INS_IN: begin
            it    = 1'b1;
            a_nxt = end_r ? tdis_pkg::WORD_LAST : {8'd0, chr_r};
          end
          tdis_pkg::INS_HALT: halt = 1'b1;
          default: ;
        endcase
      end
      tdis_pkg::ST_CRAZY: begin
        if (crz_done) begin
          fin       = 1'b1;
          a_nxt     = crz_result;
          mem_we    = 1'b1;
          mem_wdata = crz_result;
        end
      end
      default: ;
    endcase
    if (fin) begin
      if (halt) begin
        halted_nxt = 1'b1;
      end else begin
        c_nxt = tdis_pkg::wrap_next(c_tmp);
        d_nxt = tdis_pkg::wrap_next(d_tmp);
      end
      out_strobe_nxt = 1'b1;
      out_item_nxt   = '{out_valid: ov, out_byte: ob, input_taken: it, halted: halt};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tdis_pkg::ST_IDLE;
      a_r          <= '0;
      c_r          <= '0;
      d_r          <= '0;
      halted_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      a_r          <= a_nxt;
      c_r          <= c_nxt;
      d_r          <= d_nxt;
      halted_r     <= halted_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ins_r      <= ins_nxt;
    chr_r      <= chr_nxt;
    end_r      <= end_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

`ifndef SYNTHESIS
  a_beat_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> (state_r == tdis_pkg::ST_IDLE))
    else $error("result beat while a step is in flight");

  a_out_not_halted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_item_r.out_valid) |-> (!out_item_r.halted && !out_item_r.input_taken))
    else $error("output byte together with halt or input");

  a_halt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tdis_pkg::ST_IDLE && !start) |=> $stable(halted_r))
    else $error("halt flag changed without an item");

  a_crazy_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tdis_pkg::ST_CRAZY && crz_done) |-> mem_we)
    else $error("crazy result not written back");
`endif

endmodule
